// File: hw/rtl/kgis_pkg.sv
// Shared types, constants and helpers for the keyed group index scanner.
`timescale 1ns / 1ps

package kgis_pkg;

  // Field widths
  localparam int unsigned SizeBits  = 24;
  localparam int unsigned CountBits = 17;
  localparam int unsigned HashBits  = 32;
  localparam int unsigned IdxBits   = 2;

  // Default width of the reported group offset
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // FNV-1a constants
  localparam logic [HashBits-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [HashBits-1:0] FNV_PRIME = 32'h0100_0193;

  // Register indexes on the configuration port
  localparam logic [IdxBits-1:0] REG_DATA_SIZE   = 2'd0;
  localparam logic [IdxBits-1:0] REG_GROUP_COUNT = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_ENTRY    = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // Parse phase of the scanner
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_KEY   = 3'd1,
    PH_COUNT = 3'd2,
    PH_CLEN  = 3'd3,
    PH_CBODY = 3'd4
  } phase_e;

  // One result transaction
  typedef struct packed {
    logic [HashBits-1:0] hash;
    logic [SizeBits-1:0] offset;
    logic [1:0]          status;
    logic                final_res;
  } res_t;

  // UTF-8 sequence length from its lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & 8'h80) == 8'h00) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/kgis_out_reg.sv
// Output register holding one result transaction until the sink takes it.
`timescale 1ns / 1ps

module kgis_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  kgis_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output kgis_pkg::res_t res_o
);
  import kgis_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Free when empty or being drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || ready_i))
    else $error("result loaded over an untaken result");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not shown");
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ready_i && !load_i) |=> !valid_q)
    else $error("taken result still shown");
`endif

endmodule

// File: hw/rtl/kgis_scan.sv
// Input register and per-byte group parser with FNV-1a hashing.
`timescale 1ns / 1ps

module kgis_scan #(
  parameter int unsigned OFFSET_BITS = kgis_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [7:0]                         in_byte_i,
  output logic                               in_ready_o,
  input  logic                               out_free_i,
  input  logic                               cfg_we_i,
  input  logic [kgis_pkg::IdxBits-1:0]       cfg_idx_i,
  input  logic [kgis_pkg::SizeBits-1:0]      cfg_data_i,
  output logic                               res_valid_o,
  output kgis_pkg::res_t                     res_o
);
  import kgis_pkg::*;

  // Stored group start is the narrower of OFFSET_BITS and SizeBits
  localparam int unsigned GsBits = (OFFSET_BITS < SizeBits) ? OFFSET_BITS : SizeBits;

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       fire;

  // Configuration
  logic [SizeBits-1:0]  data_size_q;
  logic [CountBits-1:0] group_count_q;
  logic                 restart;

  // Scan state
  phase_e               phase_q, phase_d;
  logic [SizeBits-1:0]  position_q, position_d;
  logic [CountBits-1:0] groups_done_q, groups_done_d;
  logic [HashBits-1:0]  hash_q, hash_d;
  logic [1:0]           key_left_q, key_left_d;
  logic [7:0]           cand_left_q, cand_left_d;
  logic [7:0]           body_left_q, body_left_d;
  logic [GsBits-1:0]    group_start_q, group_start_d;
  logic                 stopped_q, stopped_d;

  // Decoded conditions
  logic                 active;
  logic [2:0]           len;
  logic [1:0]           len_m1;
  logic [SizeBits:0]    pos_w, size_w;
  logic [SizeBits-1:0]  pos_inc;
  logic                 lim_hit, lead_bad, lead_trunc, pos_end;
  logic                 clen_bad, key_last, body_last, cand_last;
  logic [CountBits:0]   groups_inc;
  logic [HashBits-1:0]  mix;
  logic [HashBits-1:0]  hash_next;
  logic                 emit_entry, emit_err1, emit_err2, stop_quiet;
  logic [GsBits-1:0]    res_start;

  // Input handshake: a byte is processed whenever the result side has room
  assign fire       = in_valid_q && out_free_i;
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Register writes; a write to a known register restarts the scan
  assign restart = cfg_we_i && (cfg_idx_i == REG_DATA_SIZE || cfg_idx_i == REG_GROUP_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q   <= '0;
      group_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DATA_SIZE:   data_size_q   <= cfg_data_i;
        REG_GROUP_COUNT: group_count_q <= cfg_data_i[CountBits-1:0];
        default: ;
      endcase
    end
  end

  // Shared decode
  assign active     = fire && !stopped_q;
  assign len        = lead_len(in_byte_q);
  assign len_m1     = 2'(len - 3'd1);
  assign pos_w      = {1'b0, position_q};
  assign size_w     = {1'b0, data_size_q};
  assign pos_inc    = position_q + 1'b1;
  assign lim_hit    = (groups_done_q >= group_count_q) || (position_q >= data_size_q);
  assign lead_bad   = (len == 3'd0);
  assign lead_trunc = (pos_w + (SizeBits+1)'(len) + 1'b1) > size_w;
  assign pos_end    = pos_inc >= data_size_q;
  assign clen_bad   = (in_byte_q == 8'd0) ||
                      (({1'b0, pos_inc} + (SizeBits+1)'(in_byte_q)) > size_w);
  assign key_last   = (key_left_q == 2'd1);
  assign body_last  = (body_left_q == 8'd1);
  assign cand_last  = (cand_left_q == 8'd1);
  assign groups_inc = {1'b0, groups_done_q} + 1'b1;

  // FNV-1a step; a lead byte starts from the offset basis
  assign mix       = ((phase_q == PH_LEAD) ? FNV_BASIS : hash_q) ^ HashBits'(in_byte_q);
  assign hash_next = HashBits'(mix * FNV_PRIME);

  // Events of this byte
  always_comb begin
    emit_entry = 1'b0;
    emit_err1  = 1'b0;
    emit_err2  = 1'b0;
    stop_quiet = 1'b0;
    if (active) begin
      unique case (phase_q)
        PH_LEAD: begin
          stop_quiet = lim_hit;
          emit_err1  = !lim_hit && lead_bad;
          emit_err2  = !lim_hit && !lead_bad && lead_trunc;
        end
        PH_COUNT: begin
          emit_entry = (in_byte_q == 8'd0);
          emit_err2  = (in_byte_q != 8'd0) && pos_end;
        end
        PH_CLEN: begin
          emit_err2 = clen_bad;
        end
        PH_CBODY: begin
          emit_entry = body_last && cand_last;
          emit_err2  = body_last && !cand_last && pos_end;
        end
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (restart) begin
      phase_d = PH_LEAD;
    end else if (active) begin
      if (emit_entry || emit_err1 || emit_err2) begin
        phase_d = PH_LEAD;
      end else begin
        unique case (phase_q)
          PH_LEAD:  if (!lim_hit) phase_d = (len_m1 != 2'd0) ? PH_KEY : PH_COUNT;
          PH_KEY:   if (key_last) phase_d = PH_COUNT;
          PH_COUNT: phase_d = PH_CLEN;
          PH_CLEN:  phase_d = PH_CBODY;
          PH_CBODY: if (body_last) phase_d = PH_CLEN;
          default:  phase_d = PH_LEAD;
        endcase
      end
    end
  end

  // Datapath and counters
  always_comb begin
    position_d    = position_q;
    groups_done_d = groups_done_q;
    hash_d        = hash_q;
    key_left_d    = key_left_q;
    cand_left_d   = cand_left_q;
    body_left_d   = body_left_q;
    group_start_d = group_start_q;
    stopped_d     = stopped_q;
    if (restart) begin
      position_d    = '0;
      groups_done_d = '0;
      hash_d        = FNV_BASIS;
      key_left_d    = '0;
      cand_left_d   = '0;
      body_left_d   = '0;
      group_start_d = '0;
      stopped_d     = 1'b0;
    end else if (active) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (!lim_hit) begin
            group_start_d = position_q[GsBits-1:0];
            if (!lead_bad && !lead_trunc) begin
              hash_d     = hash_next;
              position_d = pos_inc;
              key_left_d = len_m1;
            end
          end
        end
        PH_KEY: begin
          hash_d     = hash_next;
          position_d = pos_inc;
          key_left_d = key_left_q - 1'b1;
        end
        PH_COUNT: begin
          position_d  = pos_inc;
          cand_left_d = in_byte_q;
        end
        PH_CLEN: begin
          position_d  = pos_inc;
          body_left_d = in_byte_q;
        end
        PH_CBODY: begin
          position_d  = pos_inc;
          body_left_d = body_left_q - 1'b1;
          if (body_last) begin
            cand_left_d = cand_left_q - 1'b1;
          end
        end
        default: ;
      endcase
      if (emit_entry) begin
        groups_done_d = groups_inc[CountBits-1:0];
      end
      if (stop_quiet || emit_err1 || emit_err2 || (emit_entry && res_o.final_res)) begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_LEAD;
      position_q    <= '0;
      groups_done_q <= '0;
      hash_q        <= FNV_BASIS;
      key_left_q    <= '0;
      cand_left_q   <= '0;
      body_left_q   <= '0;
      group_start_q <= '0;
      stopped_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      position_q    <= position_d;
      groups_done_q <= groups_done_d;
      hash_q        <= hash_d;
      key_left_q    <= key_left_d;
      cand_left_q   <= cand_left_d;
      body_left_q   <= body_left_d;
      group_start_q <= group_start_d;
      stopped_q     <= stopped_d;
    end
  end

  // Result of this byte; a lead-byte error reports the lead's own offset
  assign res_start   = (phase_q == PH_LEAD) ? position_q[GsBits-1:0] : group_start_q;
  assign res_valid_o = emit_entry || emit_err1 || emit_err2;

  always_comb begin
    res_o.offset = SizeBits'(res_start);
    if (emit_entry) begin
      res_o.hash      = (hash_q == '0) ? HashBits'(1) : hash_q;
      res_o.status    = ST_ENTRY;
      res_o.final_res = (groups_inc >= {1'b0, group_count_q}) || pos_end;
    end else begin
      res_o.hash      = '0;
      res_o.status    = emit_err1 ? ST_BAD_LEAD : ST_TRUNC;
      res_o.final_res = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_entry_hash_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_ENTRY) |-> (res_o.hash != '0))
    else $error("entry result with zero hash");
  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_ENTRY) |-> (res_o.final_res && res_o.hash == '0))
    else $error("error result not final or with hash");
  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.final_res && !cfg_we_i) |=> stopped_q)
    else $error("scan not stopped after final result");
  a_quiet_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !res_valid_o)
    else $error("result while scan stopped");
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q && !restart) |=> stopped_q)
    else $error("scan resumed without register write");
`endif

endmodule

// File: hw/rtl/keyed_group_index_scanner.sv
// Top level of the keyed group index scanner.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries the group area, one byte per transaction, from offset zero.
//   m_axis carries one result per complete group (hash, start offset) or one
//   error result; tuser holds the status, tlast marks the result ending the scan.
//   cfg_we_i/cfg_idx_i/cfg_data_i write data_size (index 0) or group_count
//   (index 1); either write restarts the scan from offset zero. Write only
//   while no byte is in flight and no result is waiting.
// Path: an accepted byte waits in the input register of kgis_scan, and its
//   result is loaded into the kgis_out_reg result register that drives m_axis.
// Throughput: one byte per cycle unless m_axis stalls; each byte takes one
//   parser pass and one constant FNV multiply between input and result regs.
// Reset: both registers are zero, so the first byte stops the scan silently
//   until the registers are written.
// Stall: while m_axis_tready is low and a result waits, the parser holds and
//   s_axis_tready drops once the input register is full; bytes after a stop
//   are still accepted and discarded.
module keyed_group_index_scanner #(
  parameter int unsigned OFFSET_BITS = kgis_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata: [7:0] data_byte
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // m_axis_tdata: [31:0] entry_hash, [55:32] entry_offset
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,
  // m_axis_tuser: [1:0] status
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [kgis_pkg::IdxBits-1:0]  cfg_idx_i,
  input  logic [kgis_pkg::SizeBits-1:0] cfg_data_i
);
  import kgis_pkg::*;

  logic out_free;
  logic res_valid;
  res_t res;
  res_t out_res;

  // Byte parser
  kgis_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register
  kgis_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .free_o (out_free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {out_res.offset, out_res.hash};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.final_res;

endmodule
